### hw/rtl/mkfp_pkg.sv
// Shared types and constants for the Morton key generator.
`timescale 1ns / 1ps
`default_nettype none

package mkfp_pkg;

    // Field widths
    localparam int COORD_BITS = 32;
    localparam int IN_ID_BITS = 20;
    localparam int AXIS_BITS  = 10;
    localparam int ID_BITS    = 20;
    localparam int KEY_BITS   = 3 * AXIS_BITS;
    localparam int NUM_AXES   = 3;

    // Configuration port
    localparam int DATA_BITS  = 32;
    localparam int ADDR_BITS  = 5;

    // Queue between classifier and divider pipeline
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [ID_BITS-1:0]    t_leaf_out;
    typedef logic [KEY_BITS-1:0]   t_key;

    // Register indexes (byte address 4*index)
    typedef enum logic [2:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_LEN_X = 3'd3,
        REG_LEN_Y = 3'd4,
        REG_LEN_Z = 3'd5
    } t_reg_idx;

    // How the cell of one axis is formed
    typedef enum logic [1:0] {
        CELL_DIV,   // offset strictly inside the box: divide
        CELL_ZERO,  // below the minimum or zero extent
        CELL_FULL   // on or beyond the far face: top cell
    } t_cell_kind;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
        logic [IN_ID_BITS-1:0]        leaf_id;
    } t_in_beat;

    typedef struct packed {
        t_key      morton_key;
        t_leaf_out leaf_id_out;
    } t_out_beat;

    // Scene box, index 0 = x, 1 = y, 2 = z
    typedef struct packed {
        t_coord [NUM_AXES-1:0] box_min;
        t_coord [NUM_AXES-1:0] box_len;
    } t_box_cfg;

    typedef struct packed {
        t_cell_kind kind;
        t_coord     num;   // clamped offset, below the extent for CELL_DIV
    } t_axis_cls;

    typedef struct packed {
        t_axis_cls [NUM_AXES-1:0] axis;
        logic [IN_ID_BITS-1:0]    leaf_id;
    } t_cls_item;

endpackage

`default_nettype wire

### hw/rtl/mkfp_regs.sv
// Scene box configuration registers behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module mkfp_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mkfp_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [mkfp_pkg::DATA_BITS-1:0] pwdata,
    output logic      [mkfp_pkg::DATA_BITS-1:0] prdata,
    output logic                                pready,
    output mkfp_pkg::t_box_cfg                  o_cfg
);

    mkfp_pkg::t_box_cfg r_cfg;
    mkfp_pkg::t_reg_idx idx;
    logic               wr_en;

    assign idx    = mkfp_pkg::t_reg_idx'(paddr[mkfp_pkg::ADDR_BITS-1:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (idx)
                mkfp_pkg::REG_MIN_X: r_cfg.box_min[0] <= pwdata;
                mkfp_pkg::REG_MIN_Y: r_cfg.box_min[1] <= pwdata;
                mkfp_pkg::REG_MIN_Z: r_cfg.box_min[2] <= pwdata;
                mkfp_pkg::REG_LEN_X: r_cfg.box_len[0] <= pwdata;
                mkfp_pkg::REG_LEN_Y: r_cfg.box_len[1] <= pwdata;
                mkfp_pkg::REG_LEN_Z: r_cfg.box_len[2] <= pwdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (idx)
            mkfp_pkg::REG_MIN_X: prdata = r_cfg.box_min[0];
            mkfp_pkg::REG_MIN_Y: prdata = r_cfg.box_min[1];
            mkfp_pkg::REG_MIN_Z: prdata = r_cfg.box_min[2];
            mkfp_pkg::REG_LEN_X: prdata = r_cfg.box_len[0];
            mkfp_pkg::REG_LEN_Y: prdata = r_cfg.box_len[1];
            mkfp_pkg::REG_LEN_Z: prdata = r_cfg.box_len[2];
            default:             prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/mkfp_front.sv
// Front end: takes input beats, clamps each axis offset and classifies it.
`timescale 1ns / 1ps
`default_nettype none

module mkfp_front (
    input  wire logic               i_valid,
    input  mkfp_pkg::t_in_beat      i_beat,
    output logic                    o_stall,
    input  mkfp_pkg::t_box_cfg      i_cfg,
    output logic                    o_push,
    output mkfp_pkg::t_cls_item     o_item,
    input  wire logic               i_full
);

    localparam int CB = mkfp_pkg::COORD_BITS;

    // offset = point - min (exact, 33 bits), then clamp against the extent
    function automatic mkfp_pkg::t_axis_cls classify(mkfp_pkg::t_coord p,
                                                     mkfp_pkg::t_coord m,
                                                     mkfp_pkg::t_coord len);
        logic signed [CB:0]  off;
        mkfp_pkg::t_axis_cls c;
        off    = $signed({p[CB-1], p}) - $signed({m[CB-1], m});
        c.num  = '0;
        c.kind = mkfp_pkg::CELL_ZERO;
        if (len == '0 || off[CB]) begin
            c.kind = mkfp_pkg::CELL_ZERO;
        end else if ($unsigned(off) >= {1'b0, len}) begin
            c.kind = mkfp_pkg::CELL_FULL;
        end else begin
            c.kind = mkfp_pkg::CELL_DIV;
            c.num  = off[CB-1:0];
        end
        return c;
    endfunction

    always_comb begin
        o_item.axis[0] = classify(i_beat.point_x, i_cfg.box_min[0], i_cfg.box_len[0]);
        o_item.axis[1] = classify(i_beat.point_y, i_cfg.box_min[1], i_cfg.box_len[1]);
        o_item.axis[2] = classify(i_beat.point_z, i_cfg.box_min[2], i_cfg.box_len[2]);
        o_item.leaf_id = i_beat.leaf_id;
    end

    // a beat enters the queue whenever there is room
    assign o_push  = i_valid && !i_full;
    assign o_stall = i_full;

endmodule

`default_nettype wire

### hw/rtl/mkfp_queue.sv
// Small FIFO between the classifier and the divider pipeline.
`timescale 1ns / 1ps
`default_nettype none

module mkfp_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  mkfp_pkg::t_cls_item i_item,
    output logic                o_full,
    output logic                o_vld,
    output mkfp_pkg::t_cls_item o_head,
    input  wire logic           i_pop
);

    mkfp_pkg::t_cls_item                 r_mem [mkfp_pkg::Q_DEPTH];
    logic [mkfp_pkg::Q_PTR_BITS-1:0]     r_wr_ptr;
    logic [mkfp_pkg::Q_PTR_BITS-1:0]     r_rd_ptr;
    logic [mkfp_pkg::Q_CNT_BITS-1:0]     r_count;
    logic                                push;
    logic                                pop;

    assign o_full = (r_count == mkfp_pkg::Q_CNT_BITS'(mkfp_pkg::Q_DEPTH));
    assign o_vld  = (r_count != '0);
    assign o_head = r_mem[r_rd_ptr];
    assign push   = i_push && !o_full;
    assign pop    = i_pop && o_vld;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mkfp_pkg::Q_CNT_BITS'(mkfp_pkg::Q_DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> r_count == mkfp_pkg::Q_CNT_BITS'($past(r_count) + 1'b1))
        else $error("queue count did not follow a lone push");
`endif

endmodule

`default_nettype wire

### hw/rtl/mkfp_back.sv
// Back end: pipelined restoring divider per axis, bit interleave, output register.
`timescale 1ns / 1ps
`default_nettype none

module mkfp_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_vld,
    input  mkfp_pkg::t_cls_item i_item,
    output logic                o_pop,
    input  mkfp_pkg::t_box_cfg  i_cfg,
    output logic                o_valid,
    output mkfp_pkg::t_out_beat o_beat,
    input  wire logic           i_stall
);

    localparam int AB = mkfp_pkg::AXIS_BITS;
    localparam int CB = mkfp_pkg::COORD_BITS;
    localparam int NA = mkfp_pkg::NUM_AXES;

    typedef struct packed {
        mkfp_pkg::t_cell_kind kind;
        mkfp_pkg::t_coord     rem;
        logic [AB-1:0]        quo;
    } t_axis_step;

    typedef struct packed {
        t_axis_step [NA-1:0]             ax;
        logic [mkfp_pkg::IN_ID_BITS-1:0] leaf_id;
    } t_stage;

    t_stage              r_stg [0:AB];
    t_stage              n_stg [0:AB];
    logic [AB:0]         r_vld;
    logic                r_out_vld;
    mkfp_pkg::t_out_beat r_out;
    mkfp_pkg::t_out_beat n_out;
    logic                en;
    logic [AB-1:0]       axis_val [NA];

    // whole pipeline moves unless a finished beat is held
    assign en      = !(r_out_vld && i_stall);
    assign o_pop   = en && i_vld;
    assign o_valid = r_out_vld;
    assign o_beat  = r_out;

    // stage 0 load and one quotient bit per stage
    always_comb begin
        logic [CB:0] dbl;
        logic [CB:0] diff;
        logic        ge;
        dbl  = '0;
        diff = '0;
        ge   = 1'b0;
        for (int a = 0; a < NA; a++) begin
            n_stg[0].ax[a].kind = i_item.axis[a].kind;
            n_stg[0].ax[a].rem  = i_item.axis[a].num;
            n_stg[0].ax[a].quo  = '0;
        end
        n_stg[0].leaf_id = i_item.leaf_id;
        for (int s = 0; s < AB; s++) begin
            for (int a = 0; a < NA; a++) begin
                dbl  = {r_stg[s].ax[a].rem, 1'b0};
                diff = dbl - {1'b0, i_cfg.box_len[a]};
                ge   = (dbl >= {1'b0, i_cfg.box_len[a]});
                n_stg[s+1].ax[a].kind = r_stg[s].ax[a].kind;
                n_stg[s+1].ax[a].rem  = ge ? diff[CB-1:0] : dbl[CB-1:0];
                n_stg[s+1].ax[a].quo  = {r_stg[s].ax[a].quo[AB-2:0], ge};
            end
            n_stg[s+1].leaf_id = r_stg[s].leaf_id;
        end
    end

    // final cell per axis
    always_comb begin
        for (int a = 0; a < NA; a++) begin
            case (r_stg[AB].ax[a].kind)
                mkfp_pkg::CELL_DIV:  axis_val[a] = r_stg[AB].ax[a].quo;
                mkfp_pkg::CELL_FULL: axis_val[a] = '1;
                default:             axis_val[a] = '0;
            endcase
        end
    end

    // interleave: x in the top bit of each triple, z in the bottom
    always_comb begin
        n_out.morton_key = '0;
        for (int k = 0; k < AB; k++) begin
            n_out.morton_key[3*k+2] = axis_val[0][k];
            n_out.morton_key[3*k+1] = axis_val[1][k];
            n_out.morton_key[3*k]   = axis_val[2][k];
        end
        n_out.leaf_id_out = mkfp_pkg::t_leaf_out'(r_stg[AB].leaf_id);
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[AB-1:0], i_vld};
            r_out_vld <= r_vld[AB];
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s <= AB; s++) begin
                r_stg[s] <= n_stg[s];
            end
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |=> $stable(r_vld))
        else $error("divider pipeline moved while output held");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_out_vld && i_stall) |=> r_out_vld == $past(r_vld[AB]))
        else $error("last divider stage not passed to output");
`endif

endmodule

`default_nettype wire

### hw/rtl/morton_key_from_point_core.sv
// Top level of the 3-D Morton key generator for primitive centroids.
//
// Input channel: i_in_valid / o_in_stall carry one centroid (three signed
// Q16.16 coordinates) and a leaf id per beat. Output channel: o_out_valid /
// i_out_stall carry the 30-bit key (x in bit 3k+2, y 3k+1, z 3k) and the id.
// The scene box min and extent per axis are written through the APB port
// (byte address 4*index, pready always high, reads return the register).
// Throughput: one beat per cycle while no result beat is held by i_out_stall.
// An accepted beat passes through the queue, the pipelined per-axis divider
// that produces one quotient bit per stage, and the output register.
// Reset clears the registers to zero and empties the queue and pipeline.
// While a valid result beat is stalled the divider pipeline holds; a
// 4-entry queue keeps taking beats until full, then o_in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module morton_key_from_point_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input beats
    input  wire logic                           i_in_valid,
    input  mkfp_pkg::t_in_beat                  i_in_data,
    output logic                                o_in_stall,
    // result beats
    output logic                                o_out_valid,
    output mkfp_pkg::t_out_beat                 o_out_data,
    input  wire logic                           i_out_stall,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mkfp_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [mkfp_pkg::DATA_BITS-1:0] pwdata,
    output logic      [mkfp_pkg::DATA_BITS-1:0] prdata,
    output logic                                pready
);

    mkfp_pkg::t_box_cfg  cfg;
    mkfp_pkg::t_cls_item push_item;
    mkfp_pkg::t_cls_item head_item;
    logic                push;
    logic                q_full;
    logic                q_vld;
    logic                pop;

    mkfp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mkfp_front u_front (
        .i_valid (i_in_valid),
        .i_beat  (i_in_data),
        .o_stall (o_in_stall),
        .i_cfg   (cfg),
        .o_push  (push),
        .o_item  (push_item),
        .i_full  (q_full)
    );

    mkfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_head  (head_item),
        .i_pop   (pop)
    );

    mkfp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (q_vld),
        .i_item  (head_item),
        .o_pop   (pop),
        .i_cfg   (cfg),
        .o_valid (o_out_valid),
        .o_beat  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

`default_nettype wire

### dv/tb_morton_key_from_point_core.sv
// Self-checking testbench for the 3-D Morton key generator core.
`timescale 1ns / 1ps

// Holds the scene box, predicts the key of each accepted point and checks
// the result beats against those keys in order.
class key_checker;
    localparam int AB = mkfp_pkg::AXIS_BITS;

    mkfp_pkg::t_coord    box_min[3];
    mkfp_pkg::t_coord    box_len[3];
    mkfp_pkg::t_out_beat keys_due[$];
    int                  points_seen;
    int                  keys_checked;
    int                  errors;

    function new();
        for (int a = 0; a < 3; a++) begin
            box_min[a] = '0;
            box_len[a] = '0;
        end
        points_seen  = 0;
        keys_checked = 0;
        errors       = 0;
    endfunction

    function void set_reg(mkfp_pkg::t_reg_idx idx, mkfp_pkg::t_coord val);
        case (idx)
            mkfp_pkg::REG_MIN_X: box_min[0] = val;
            mkfp_pkg::REG_MIN_Y: box_min[1] = val;
            mkfp_pkg::REG_MIN_Z: box_min[2] = val;
            mkfp_pkg::REG_LEN_X: box_len[0] = val;
            mkfp_pkg::REG_LEN_Y: box_len[1] = val;
            mkfp_pkg::REG_LEN_Z: box_len[2] = val;
            default: ;
        endcase
    endfunction

    // Clamp the offset into [0, extent] and scale it to an AXIS_BITS cell.
    function logic [AB-1:0] cell_of(mkfp_pkg::t_coord pt, mkfp_pkg::t_coord lo,
                                    mkfp_pkg::t_coord len);
        longint off;
        longint span;
        longint q;
        if (len == '0) return '0;
        span = longint'(len);
        off  = longint'($signed(pt)) - longint'($signed(lo));
        if (off < 0) off = 0;
        else if (off > span) off = span;
        q = (off << AB) / span;
        // far face lands one past the top cell
        if (q > (longint'(1) << AB) - 1) q = (longint'(1) << AB) - 1;
        return q[AB-1:0];
    endfunction

    function mkfp_pkg::t_out_beat predict_key(mkfp_pkg::t_in_beat b);
        logic [AB-1:0] cx, cy, cz;
        mkfp_pkg::t_out_beat r;
        cx = cell_of(b.point_x, box_min[0], box_len[0]);
        cy = cell_of(b.point_y, box_min[1], box_len[1]);
        cz = cell_of(b.point_z, box_min[2], box_len[2]);
        r.morton_key = '0;
        for (int k = 0; k < AB; k++) begin
            r.morton_key[3*k+2] = cx[k];
            r.morton_key[3*k+1] = cy[k];
            r.morton_key[3*k]   = cz[k];
        end
        r.leaf_id_out = mkfp_pkg::t_leaf_out'(b.leaf_id);
        return r;
    endfunction

    function void note_point(mkfp_pkg::t_in_beat b);
        keys_due = {keys_due, predict_key(b)};
        points_seen++;
    endfunction

    function void check_key(mkfp_pkg::t_out_beat got);
        mkfp_pkg::t_out_beat want;
        if (keys_due.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result beat: key %h id %h", got.morton_key,
                         got.leaf_id_out);
            return;
        end
        want = keys_due.pop_front();
        keys_checked++;
        if (got.morton_key !== want.morton_key || got.leaf_id_out !== want.leaf_id_out) begin
            errors++;
            if (errors <= 10)
                $display("mismatch at result %0d: expected key %h id %h, got key %h id %h",
                         keys_checked, want.morton_key, want.leaf_id_out,
                         got.morton_key, got.leaf_id_out);
        end
    endfunction

    function int failures();
        return errors + keys_due.size();
    endfunction
endclass

module tb_morton_key_from_point_core;

    localparam int SETTLE_CYCLES  = 20;    // pipeline latency plus margin
    localparam int HOLD_CYCLES    = 200;   // long output hold-off
    localparam int RANDOM_PHASES  = 6;
    localparam int POINTS_PER_SET = 175;
    localparam int AW             = mkfp_pkg::ADDR_BITS;
    localparam int DW             = mkfp_pkg::DATA_BITS;
    localparam int IDW            = mkfp_pkg::IN_ID_BITS;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    mkfp_pkg::t_in_beat   i_in_data;
    logic                 o_in_stall;
    logic                 o_out_valid;
    mkfp_pkg::t_out_beat  o_out_data;
    logic                 i_out_stall;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [AW-1:0]        paddr;
    logic [DW-1:0]        pwdata;
    logic [DW-1:0]        prdata;
    logic                 pready;

    key_checker           keys;
    mkfp_pkg::t_in_beat   point_q[$];
    logic                 hold_request;
    int                   in_stall_cycles;
    int                   box_settings;

    morton_key_from_point_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Run limit
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Result sink: checks beats and stalls in random epochs, plus one long hold-off
    initial begin : result_sink
        int stall_pct;
        int epoch_left;
        int hold_left;
        stall_pct   = 0;
        epoch_left  = 0;
        hold_left   = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) keys.check_key(o_out_data);
            if (i_rst_n && i_in_valid && o_in_stall) in_stall_cycles++;
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (epoch_left == 0) begin
                    epoch_left = $urandom_range(20, 80);
                    case ($urandom_range(3))
                        0: stall_pct = 0;
                        1: stall_pct = 15;
                        2: stall_pct = 50;
                        default: stall_pct = 90;
                    endcase
                end
                epoch_left--;
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // One APB write: setup cycle, then access cycle until pready
    task automatic write_reg(mkfp_pkg::t_reg_idx idx, mkfp_pkg::t_coord val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AW'(idx) << 2;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        keys.set_reg(idx, val);
    endtask

    task automatic set_box(mkfp_pkg::t_coord mx, mkfp_pkg::t_coord my, mkfp_pkg::t_coord mz,
                           mkfp_pkg::t_coord lx, mkfp_pkg::t_coord ly, mkfp_pkg::t_coord lz);
        write_reg(mkfp_pkg::REG_MIN_X, mx);
        write_reg(mkfp_pkg::REG_MIN_Y, my);
        write_reg(mkfp_pkg::REG_MIN_Z, mz);
        write_reg(mkfp_pkg::REG_LEN_X, lx);
        write_reg(mkfp_pkg::REG_LEN_Y, ly);
        write_reg(mkfp_pkg::REG_LEN_Z, lz);
        box_settings++;
    endtask

    // Offer the queued points in bursts with random gaps
    task automatic send_points();
        int burst;
        while (point_q.size() > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && point_q.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data  <= point_q[0];
                do @(posedge i_clk); while (o_in_stall);
                keys.note_point(point_q.pop_front());
                burst--;
            end
            if ($urandom_range(3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
    endtask

    // Wait for every key to come back, then let the pipeline settle
    task automatic drain();
        while (keys.keys_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_point(mkfp_pkg::t_coord x, mkfp_pkg::t_coord y, mkfp_pkg::t_coord z,
                             logic [IDW-1:0] id);
        mkfp_pkg::t_in_beat b;
        b.point_x = x;
        b.point_y = y;
        b.point_z = z;
        b.leaf_id = id;
        point_q = {point_q, b};
    endtask

    function automatic mkfp_pkg::t_coord pick_min();
        case ($urandom_range(4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return $urandom;
            default: return $urandom_range(32'h0200_0000) - 32'h0100_0000;
        endcase
    endfunction

    function automatic mkfp_pkg::t_coord pick_len();
        case ($urandom_range(5))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 16);
            3: return $urandom;
            default: return $urandom_range(1, 32'h0400_0000);
        endcase
    endfunction

    // Coordinate mostly inside the box, a little outside, sometimes on a face
    function automatic mkfp_pkg::t_coord near_axis(mkfp_pkg::t_coord lo, mkfp_pkg::t_coord len);
        longint span;
        longint off;
        span = longint'(len);
        case ($urandom_range(11))
            0: return lo;
            1: return lo + len;
            2: return lo + len - 1;
            3: return $urandom;
            default: begin
                off = (longint'($urandom) * (span + span / 4 + 1)) >> 32;
                return mkfp_pkg::t_coord'(longint'($signed(lo)) + off - span / 8);
            end
        endcase
    endfunction

    initial begin
        keys            = new();
        hold_request    = 1'b0;
        in_stall_cycles = 0;
        box_settings    = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset box: every extent is zero, so every key is zero
        add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 20'h00000);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 20'hFFFFF);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 20'h55555);
        add_point(32'hFFFF_FFFF, 32'h0001_0000, 32'hAAAA_5555, 20'hAAAAA);
        send_points();
        drain();

        // Box x [-10, 10], y [-3.5, 3.5], z [0, 1]
        set_box(32'hFFF6_0000, 32'hFFFC_8000, 32'h0000_0000,
                32'h0014_0000, 32'h0007_0000, 32'h0001_0000);
        add_point(32'hFFF6_0000, 32'hFFFC_8000, 32'h0000_0000, 20'h00001);  // at minimum
        add_point(32'hFFF5_0000, 32'hFFFC_0000, 32'hFFFF_FFFF, 20'h00002);  // below
        add_point(32'h000A_0000, 32'h0003_8000, 32'h0001_0000, 20'hFFFFF);  // far face
        add_point(32'h0009_FFFF, 32'h0003_7FFF, 32'h0000_FFFF, 20'h7FFFF);  // just inside
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'h80000);  // beyond
        add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 20'h00000);
        add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_8000, 20'h12345);  // centers
        add_point(32'h0003_1234, 32'hFFFE_ABCD, 32'h0000_4321, 20'hABCDE);
        add_point(32'h0004_0000, 32'hFFF0_0000, 32'h0005_0000, 20'h0F0F0);  // mixed
        send_points();
        drain();

        // Extreme registers: widest x box, unit y box, zero z extent
        set_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 20'h11111);
        add_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 20'h22222);
        add_point(32'h0000_0000, 32'h7FFF_FFFE, 32'h8000_0000, 20'h33333);
        add_point(32'h7FFF_FFFE, 32'h0000_0000, 32'h1234_5678, 20'h44444);
        add_point(32'h8000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hEEEEE);
        send_points();
        drain();

        // Random boxes with points clustered around them
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            mkfp_pkg::t_coord mn[3];
            mkfp_pkg::t_coord ln[3];
            for (int a = 0; a < 3; a++) begin
                mn[a] = pick_min();
                ln[a] = pick_len();
            end
            set_box(mn[0], mn[1], mn[2], ln[0], ln[1], ln[2]);
            for (int n = 0; n < POINTS_PER_SET; n++) begin
                add_point(near_axis(mn[0], ln[0]), near_axis(mn[1], ln[1]),
                          near_axis(mn[2], ln[2]), IDW'($urandom));
            end
            // fill the block while the output is held off
            if (p == 2) hold_request = 1'b1;
            send_points();
            drain();
        end

        $display("Ran %0d points through %0d box settings plus the reset box; %0d keys checked.",
                 keys.points_seen, box_settings, keys.keys_checked);
        $display("Input was stalled on %0d cycles; %0d errors.", in_stall_cycles,
                 keys.failures());
        if (keys.failures() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/mkfp_pkg.sv
hw/rtl/mkfp_regs.sv
hw/rtl/mkfp_front.sv
hw/rtl/mkfp_queue.sv
hw/rtl/mkfp_back.sv
hw/rtl/morton_key_from_point_core.sv
dv/tb_morton_key_from_point_core.sv
